### design/eda_pkg.sv
package eda_pkg;

    localparam int EVENT_SLOTS_DEF    = 16;
    localparam int SUBS_PER_EVENT_DEF = 8;
    localparam int QUEUE_DEPTH_DEF    = 16;

    localparam int ID_W     = 16;
    localparam int HANDLE_W = 16;
    localparam int CTX_W    = 32;
    localparam int STATUS_W = 3;
    localparam int CMD_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SUBSCRIBE   = 2'd0,
        CMD_UNSUBSCRIBE = 2'd1,
        CMD_PUBLISH     = 2'd2,
        CMD_PROCESS     = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NULL_HANDLE = 3'd1,
        ST_TABLE_FULL  = 3'd2,
        ST_LIST_FULL   = 3'd3,
        ST_NOT_FOUND   = 3'd4,
        ST_QUEUE_FULL  = 3'd5,
        ST_EMPTY       = 3'd6
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;       // capture the input item
        logic scan_clear;    // restart the slot scan
        logic scan_step;     // compare one slot, advance on a miss
        logic sub_clear;     // restart subscriber index
        logic sub_step;      // advance subscriber index
        logic sub_rd;        // issue subscriber memory read at index
        logic last_rd;       // issue memory read at last subscriber
        logic new_slot;      // append a new slot with the captured id
        logic append;        // write the pair at the end of the list
        logic move_last;     // write the fetched last pair at the match
        logic fifo_push;
        logic fifo_rd;       // issue fifo read
        logic fifo_pop;      // take the fifo head as the event id
        logic out_load;      // load the output register
        logic out_deliver;   // loaded result is a delivery
        logic out_last;
        status_t out_status;
    } eda_cmd_t;

    // datapath to controller status
    typedef struct packed {
        cmd_t cmd;
        logic handle_zero;
        logic scan_done;     // all used slots compared
        logic scan_hit;
        logic table_full;
        logic list_full;
        logic list_empty;
        logic sub_end;       // index has reached the count
        logic sub_last;      // index is the last subscriber
        logic sub_match;     // fetched handle equals the request
        logic fifo_full;
        logic fifo_empty;
        logic out_busy;
    } eda_stat_t;

endpackage

### design/eda_if.sv
interface eda_in_if;
    import eda_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     ev_id;
    logic [HANDLE_W-1:0] handle;
    logic [CTX_W-1:0]    context_req;
    modport source (output valid, cmd, ev_id, handle, context_req, input ready);
    modport sink (input valid, cmd, ev_id, handle, context_req, output ready);
endinterface

interface eda_out_if;
    import eda_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                deliver;
    logic [HANDLE_W-1:0] handle_out;
    logic [CTX_W-1:0]    context_out;
    logic                last_of_run;
    logic [4:0]          pending;
    modport source (output valid, status, deliver, handle_out, context_out, last_of_run,
        pending, input ready);
    modport sink (input valid, status, deliver, handle_out, context_out, last_of_run,
        pending, output ready);
endinterface

### design/eda_ram.sv
module eda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### design/eda_datapath.sv
module eda_datapath #(
    parameter int EVENT_SLOTS    = eda_pkg::EVENT_SLOTS_DEF,
    parameter int SUBS_PER_EVENT = eda_pkg::SUBS_PER_EVENT_DEF,
    parameter int QUEUE_DEPTH    = eda_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  eda_pkg::eda_cmd_t ctl,
    output eda_pkg::eda_stat_t st,
    eda_in_if.sink           in_ch,
    eda_out_if.source        out_ch
);
    import eda_pkg::*;

    localparam int SLOT_W  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int SUB_W   = (SUBS_PER_EVENT > 1) ? $clog2(SUBS_PER_EVENT) : 1;
    localparam int CNT_W   = $clog2(SUBS_PER_EVENT + 1);
    localparam int USED_W  = $clog2(EVENT_SLOTS + 1);
    localparam int Q_W     = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int TOTAL   = EVENT_SLOTS * SUBS_PER_EVENT;
    localparam int SA_W    = $clog2(TOTAL) > 0 ? $clog2(TOTAL) : 1;

    // captured item
    logic [CMD_W-1:0]    cmd_reg;
    logic [ID_W-1:0]     id_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [CTX_W-1:0]    ctx_reg;

    // slot table, small enough for flops
    logic [ID_W-1:0]     slot_ids_reg [EVENT_SLOTS];
    logic [CNT_W-1:0]    sub_counts_reg [EVENT_SLOTS];
    logic [USED_W-1:0]   slots_used_reg;

    // scan state
    logic [USED_W-1:0]   scan_reg;
    logic                hit_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [SUB_W-1:0]    match_reg;

    // fifo pointers
    logic [Q_W-1:0]      rd_ptr_reg;
    logic [Q_W-1:0]      wr_ptr_reg;
    logic [FILL_W-1:0]   fill_reg;

    // output register
    logic                ovalid_reg;
    logic [STATUS_W-1:0] ostatus_reg;
    logic                odeliver_reg;
    logic [HANDLE_W-1:0] ohandle_reg;
    logic [CTX_W-1:0]    octx_reg;
    logic                olast_reg;

    logic [HANDLE_W-1:0] h_rdata;
    logic [CTX_W-1:0]    c_rdata;
    logic [ID_W-1:0]     q_rdata;
    logic [ID_W-1:0]     key;
    logic [SLOT_W-1:0]   scan_idx;
    logic [CNT_W-1:0]    cur_cnt;
    logic [CNT_W-1:0]    last_idx;
    logic                sub_we;
    logic [SA_W-1:0]     sub_waddr;
    logic [SA_W-1:0]     sub_raddr;
    logic [SUB_W-1:0]    rd_sub;
    logic [HANDLE_W-1:0] sub_wh;
    logic [CTX_W-1:0]    sub_wc;

    assign key      = id_reg;
    assign scan_idx = scan_reg[SLOT_W-1:0];
    assign cur_cnt  = sub_counts_reg[slot_reg];
    assign last_idx = cur_cnt - CNT_W'(1);

    // subscriber memories, row per slot
    assign rd_sub    = ctl.last_rd ? last_idx[SUB_W-1:0] : idx_reg[SUB_W-1:0];
    assign sub_raddr = SA_W'(slot_reg) * SA_W'(SUBS_PER_EVENT) + SA_W'(rd_sub);
    assign sub_we    = ctl.append | ctl.move_last;
    assign sub_waddr = SA_W'(slot_reg) * SA_W'(SUBS_PER_EVENT)
        + (ctl.append ? SA_W'(cur_cnt[SUB_W-1:0]) : SA_W'(match_reg));
    assign sub_wh    = ctl.append ? handle_reg : h_rdata;
    assign sub_wc    = ctl.append ? ctx_reg : c_rdata;

    eda_ram #(.WIDTH(HANDLE_W), .DEPTH(TOTAL)) u_handles (
        .clk(clk), .we(sub_we), .waddr(sub_waddr), .wdata(sub_wh),
        .re(ctl.sub_rd | ctl.last_rd), .raddr(sub_raddr), .rdata(h_rdata));
    eda_ram #(.WIDTH(CTX_W), .DEPTH(TOTAL)) u_contexts (
        .clk(clk), .we(sub_we), .waddr(sub_waddr), .wdata(sub_wc),
        .re(ctl.sub_rd | ctl.last_rd), .raddr(sub_raddr), .rdata(c_rdata));
    eda_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk(clk), .we(ctl.fifo_push), .waddr(wr_ptr_reg), .wdata(id_reg),
        .re(ctl.fifo_rd), .raddr(rd_ptr_reg), .rdata(q_rdata));

    // input capture
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg    <= in_ch.cmd;
            id_reg     <= in_ch.ev_id;
            handle_reg <= in_ch.handle;
            ctx_reg    <= in_ch.context_req;
        end
        else if (ctl.fifo_pop)
        begin
            id_reg <= q_rdata;
        end
    end

    // slot table writes
    always_ff @(posedge clk)
    begin
        if (ctl.new_slot)
        begin
            slot_ids_reg[slots_used_reg[SLOT_W-1:0]]   <= id_reg;
            sub_counts_reg[slots_used_reg[SLOT_W-1:0]] <= '0;
        end
        else if (ctl.append)
        begin
            sub_counts_reg[slot_reg] <= cur_cnt + CNT_W'(1);
        end
        else if (ctl.move_last)
        begin
            sub_counts_reg[slot_reg] <= last_idx;
        end
    end

    // slot scan and subscriber index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_used_reg <= '0;
            scan_reg       <= '0;
            hit_reg        <= 1'b0;
            slot_reg       <= '0;
            idx_reg        <= '0;
            match_reg      <= '0;
        end
        else
        begin
            if (ctl.new_slot)
            begin
                slots_used_reg <= slots_used_reg + USED_W'(1);
                slot_reg       <= slots_used_reg[SLOT_W-1:0];
                hit_reg        <= 1'b1;
            end
            else if (ctl.scan_clear)
            begin
                scan_reg <= '0;
                hit_reg  <= 1'b0;
            end
            else if (ctl.scan_step)
            begin
                if (slot_ids_reg[scan_idx] == key)
                begin
                    hit_reg  <= 1'b1;
                    slot_reg <= scan_idx;
                end
                else
                begin
                    scan_reg <= scan_reg + USED_W'(1);
                end
            end
            if (ctl.sub_clear)
            begin
                idx_reg <= '0;
            end
            else if (ctl.sub_step)
            begin
                match_reg <= idx_reg[SUB_W-1:0];
                idx_reg   <= idx_reg + CNT_W'(1);
            end
        end
    end

    // fifo pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (ctl.fifo_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_W'(1);
                fill_reg   <= fill_reg + FILL_W'(1);
            end
            if (ctl.fifo_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_W'(1);
                fill_reg   <= fill_reg - FILL_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            ostatus_reg  <= ctl.out_status;
            odeliver_reg <= ctl.out_deliver;
            ohandle_reg  <= ctl.out_deliver ? h_rdata : '0;
            octx_reg     <= ctl.out_deliver ? c_rdata : '0;
            olast_reg    <= ctl.out_last;
        end
    end

    assign out_ch.valid       = ovalid_reg;
    assign out_ch.status      = ostatus_reg;
    assign out_ch.deliver     = odeliver_reg;
    assign out_ch.handle_out  = ohandle_reg;
    assign out_ch.context_out = octx_reg;
    assign out_ch.last_of_run = olast_reg;
    assign out_ch.pending     = 5'(fill_reg);

    // status to controller
    assign st.cmd         = cmd_t'(cmd_reg);
    assign st.handle_zero = (handle_reg == '0);
    assign st.scan_done   = (scan_reg >= slots_used_reg);
    assign st.scan_hit    = hit_reg;
    assign st.table_full  = (slots_used_reg >= USED_W'(EVENT_SLOTS));
    assign st.list_full   = (cur_cnt >= CNT_W'(SUBS_PER_EVENT));
    assign st.list_empty  = (cur_cnt == '0);
    assign st.sub_end     = (idx_reg >= cur_cnt);
    assign st.sub_last    = (idx_reg == last_idx);
    assign st.sub_match   = (h_rdata == handle_reg);
    assign st.fifo_full   = (fill_reg >= FILL_W'(QUEUE_DEPTH));
    assign st.fifo_empty  = (fill_reg == '0);
    assign st.out_busy    = ovalid_reg & ~out_ch.ready;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill over depth");
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slots_used_reg <= USED_W'(EVENT_SLOTS))
        else $error("slot count over table size");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fifo_push |-> !st.fifo_full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fifo_rd |-> !st.fifo_empty)
        else $error("pop from empty queue");
`endif
endmodule

### design/eda_ctrl.sv
module eda_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  eda_pkg::eda_stat_t st,
    output eda_pkg::eda_cmd_t  ctl
);
    import eda_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECODE = 10'b0000000010,
        S_SCAN   = 10'b0000000100,
        S_ACT    = 10'b0000001000,
        S_URD    = 10'b0000010000,
        S_UCMP   = 10'b0000100000,
        S_UMOVE  = 10'b0001000000,
        S_QWAIT  = 10'b0010000000,
        S_DRD    = 10'b0100000000,
        S_DOUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // sequencing of one item
    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        ctl.out_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_in    = 1'b1;
                    ctl.scan_clear = 1'b1;
                    ctl.sub_clear  = 1'b1;
                    state_next     = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!st.out_busy)
                begin
                    case (st.cmd)
                        CMD_SUBSCRIBE:
                        begin
                            if (st.handle_zero)
                            begin
                                ctl.out_load   = 1'b1;
                                ctl.out_last   = 1'b1;
                                ctl.out_status = ST_NULL_HANDLE;
                                state_next     = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_UNSUBSCRIBE:
                            state_next = S_SCAN;
                        CMD_PUBLISH:
                        begin
                            ctl.out_load = 1'b1;
                            ctl.out_last = 1'b1;
                            if (st.fifo_full)
                            begin
                                ctl.out_status = ST_QUEUE_FULL;
                            end
                            else
                            begin
                                ctl.fifo_push = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            if (st.fifo_empty)
                            begin
                                ctl.out_load   = 1'b1;
                                ctl.out_last   = 1'b1;
                                ctl.out_status = ST_EMPTY;
                                state_next     = S_IDLE;
                            end
                            else
                            begin
                                ctl.fifo_rd = 1'b1;
                                state_next  = S_QWAIT;
                            end
                        end
                    endcase
                end
            end
            S_QWAIT:
            begin
                ctl.fifo_pop = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                if (st.scan_hit || st.scan_done)
                begin
                    state_next = S_ACT;
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                end
            end
            S_ACT:
            begin
                case (st.cmd)
                    CMD_SUBSCRIBE:
                    begin
                        if (!st.scan_hit && !st.table_full)
                        begin
                            ctl.new_slot = 1'b1;
                        end
                        else
                        begin
                            ctl.out_load = 1'b1;
                            ctl.out_last = 1'b1;
                            if (!st.scan_hit)
                            begin
                                ctl.out_status = ST_TABLE_FULL;
                            end
                            else if (st.list_full)
                            begin
                                ctl.out_status = ST_LIST_FULL;
                            end
                            else
                            begin
                                ctl.append = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    CMD_UNSUBSCRIBE:
                    begin
                        if (!st.scan_hit || st.sub_end)
                        begin
                            ctl.out_load   = 1'b1;
                            ctl.out_last   = 1'b1;
                            ctl.out_status = ST_NOT_FOUND;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            ctl.sub_rd = 1'b1;
                            state_next = S_UCMP;
                        end
                    end
                    default:
                    begin
                        if (!st.scan_hit || st.list_empty)
                        begin
                            ctl.out_load   = 1'b1;
                            ctl.out_last   = 1'b1;
                            ctl.out_status = st.scan_hit ? ST_OK : ST_NOT_FOUND;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            ctl.sub_rd = 1'b1;
                            state_next = S_DOUT;
                        end
                    end
                endcase
            end
            S_UCMP:
            begin
                ctl.sub_step = 1'b1;
                if (st.sub_match)
                begin
                    ctl.last_rd = 1'b1;
                    state_next  = S_UMOVE;
                end
                else
                begin
                    state_next = S_URD;
                end
            end
            S_URD:
            begin
                if (st.sub_end)
                begin
                    if (!st.out_busy)
                    begin
                        ctl.out_load   = 1'b1;
                        ctl.out_last   = 1'b1;
                        ctl.out_status = ST_NOT_FOUND;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    ctl.sub_rd = 1'b1;
                    state_next = S_UCMP;
                end
            end
            S_UMOVE:
            begin
                if (!st.out_busy)
                begin
                    ctl.move_last = 1'b1;
                    ctl.out_load  = 1'b1;
                    ctl.out_last  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DRD:
            begin
                ctl.sub_rd = 1'b1;
                state_next = S_DOUT;
            end
            S_DOUT:
            begin
                if (!st.out_busy)
                begin
                    ctl.out_load    = 1'b1;
                    ctl.out_deliver = 1'b1;
                    ctl.out_last    = st.sub_last;
                    ctl.sub_step    = 1'b1;
                    state_next      = st.sub_last ? S_IDLE : S_DRD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> !st.out_busy)
        else $error("result overwritten");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_in |=> state_reg == S_DECODE)
        else $error("accept did not start decode");
`endif
endmodule

### design/event_dispatch_engine_unit.sv
// timing: publish, null handle and empty process results are loaded in the decode
// state after accept, once the output register is free; other items first run the slot scan
// sequencing: one item at a time, next accept in the cycle after its last result is
// loaded; process emits each delivery from its read and output states when the sink is ready
// reset: rst_n async low clears control, fifo pointers and slot count; memories keep
// contents and are never read before written
module event_dispatch_engine_unit #(
    parameter int EVENT_SLOTS    = eda_pkg::EVENT_SLOTS_DEF,
    parameter int SUBS_PER_EVENT = eda_pkg::SUBS_PER_EVENT_DEF,
    parameter int QUEUE_DEPTH    = eda_pkg::QUEUE_DEPTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    eda_in_if.sink    in_ch,
    eda_out_if.source out_ch
);
    import eda_pkg::*;

    eda_cmd_t  ctl;
    eda_stat_t st;

    eda_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .st(st), .ctl(ctl));

    eda_datapath #(
        .EVENT_SLOTS(EVENT_SLOTS), .SUBS_PER_EVENT(SUBS_PER_EVENT),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .st(st), .in_ch(in_ch), .out_ch(out_ch));
endmodule
